>>> hdl/pdcd_pkg.sv
package pdcd_pkg;

    // sensor array and fixed-point formats
    localparam int SENSOR_COUNT = 2;
    localparam int SAMPLE_BITS  = 10;
    localparam int FRAC_BITS    = 8;

    // widths of fields and registers
    localparam int WEIGHT_W   = 17;
    localparam int FS_W       = 10;
    localparam int DEADBAND_W = 10;
    localparam int PCT_W      = 7;
    localparam int TIME_W     = 32;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // datapath widths
    localparam int Q_W    = SAMPLE_BITS + FRAC_BITS;
    localparam int PROD_W = WEIGHT_W + Q_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int D_W    = FS_W + FRAC_BITS;
    localparam int DB_W   = DEADBAND_W + FRAC_BITS;
    localparam int WIDE_W = (Q_W > D_W) ? ((Q_W > DB_W) ? Q_W : DB_W)
                                        : ((D_W > DB_W) ? D_W : DB_W);
    localparam int NUM_W  = WIDE_W + 9;
    localparam int STEP_W = $clog2(PCT_W);

    localparam logic [WEIGHT_W-1:0] ONE_Q16     = WEIGHT_W'(65536);
    localparam logic [ACC_W-1:0]    FILT_ROUND  = ACC_W'(1) << 15;
    localparam logic [ACC_W-1:0]    TRK_ROUND   = ACC_W'(1) << (15 + FRAC_BITS);
    localparam logic [PCT_W-1:0]    PCT_FULL    = PCT_W'(100);
    localparam logic [NUM_W-1:0]    PCT_SCALE   = NUM_W'(200);
    localparam logic [NUM_W-1:0]    PCT_SAT_MUL = NUM_W'(201);

    // register reset values
    localparam logic [WEIGHT_W-1:0]    FILTER_ALPHA_RST = WEIGHT_W'(9830);
    localparam logic [WEIGHT_W-1:0]    TRACK_ALPHA_RST  = WEIGHT_W'(6554);
    localparam logic [FS_W-1:0]        FULL_SCALE_RST   = FS_W'(24);
    localparam logic [DEADBAND_W-1:0]  DEADBAND_RST     = DEADBAND_W'(2);
    localparam logic [PCT_W-1:0]       THRESHOLD_RST    = PCT_W'(12);
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST      = TIMEOUT_W'(250);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX       = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ALPHA = 3'd0,
        CFG_TRACK_ALPHA  = 3'd1,
        CFG_FULL_SCALE   = 3'd2,
        CFG_DEADBAND     = 3'd3,
        CFG_THRESHOLD    = 3'd4,
        CFG_TIMEOUT      = 3'd5
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FILT_MUL,
        ST_FILT_ACC,
        ST_BASE_CMP,
        ST_TRK1_MUL,
        ST_TRK1_ACC,
        ST_ZONE,
        ST_ZONE_CHK,
        ST_TRK2_MUL,
        ST_TRK2_ACC,
        ST_PCT,
        ST_DIV,
        ST_COMMIT,
        ST_REPORT
    } state_t;

    typedef enum logic {
        FUNC_INIT   = 1'b0,
        FUNC_UPDATE = 1'b1
    } func_t;

    typedef struct packed {
        logic capture;
        logic filt_mul;
        logic filt_acc;
        logic trk_mul;
        logic trk_acc;
        logic zone_calc;
        logic pct_calc;
        logic div_step;
        logic commit;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_update;
        logic above_base;
        logic zone;
        logic div_needed;
        logic out_free;
    } status_t;

endpackage

>>> hdl/pdcd_ctrl.sv
module pdcd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pdcd_pkg::status_t  status,
    output pdcd_pkg::cmd_t     cmd
);

    pdcd_pkg::state_t                 state_reg, state_next;
    logic [pdcd_pkg::STEP_W-1:0]      step_cnt_reg, step_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pdcd_pkg::ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            pdcd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = pdcd_pkg::ST_DISPATCH;
                end
            end
            pdcd_pkg::ST_DISPATCH: begin
                state_next = status.is_update ? pdcd_pkg::ST_FILT_MUL : pdcd_pkg::ST_COMMIT;
            end
            pdcd_pkg::ST_FILT_MUL: begin
                cmd.filt_mul = 1'b1;
                state_next   = pdcd_pkg::ST_FILT_ACC;
            end
            pdcd_pkg::ST_FILT_ACC: begin
                cmd.filt_acc = 1'b1;
                state_next   = pdcd_pkg::ST_BASE_CMP;
            end
            pdcd_pkg::ST_BASE_CMP: begin
                state_next = status.above_base ? pdcd_pkg::ST_TRK1_MUL : pdcd_pkg::ST_ZONE;
            end
            pdcd_pkg::ST_TRK1_MUL: begin
                cmd.trk_mul = 1'b1;
                state_next  = pdcd_pkg::ST_TRK1_ACC;
            end
            pdcd_pkg::ST_TRK1_ACC: begin
                cmd.trk_acc = 1'b1;
                state_next  = pdcd_pkg::ST_ZONE;
            end
            pdcd_pkg::ST_ZONE: begin
                cmd.zone_calc = 1'b1;
                state_next    = pdcd_pkg::ST_ZONE_CHK;
            end
            pdcd_pkg::ST_ZONE_CHK: begin
                state_next = status.zone ? pdcd_pkg::ST_TRK2_MUL : pdcd_pkg::ST_PCT;
            end
            pdcd_pkg::ST_TRK2_MUL: begin
                cmd.trk_mul = 1'b1;
                state_next  = pdcd_pkg::ST_TRK2_ACC;
            end
            pdcd_pkg::ST_TRK2_ACC: begin
                cmd.trk_acc = 1'b1;
                state_next  = pdcd_pkg::ST_PCT;
            end
            pdcd_pkg::ST_PCT: begin
                cmd.pct_calc  = 1'b1;
                step_cnt_next = '0;
                state_next    = status.div_needed ? pdcd_pkg::ST_DIV : pdcd_pkg::ST_COMMIT;
            end
            pdcd_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (step_cnt_reg == pdcd_pkg::STEP_W'(pdcd_pkg::PCT_W - 1)) begin
                    state_next = pdcd_pkg::ST_COMMIT;
                end else begin
                    step_cnt_next = step_cnt_reg + 1'b1;
                end
            end
            pdcd_pkg::ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = pdcd_pkg::ST_REPORT;
            end
            pdcd_pkg::ST_REPORT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = pdcd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdcd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/pdcd_datapath.sv
module pdcd_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pdcd_pkg::cmd_t                      cmd,
    output pdcd_pkg::status_t                   status,
    input  logic                                in_func,
    input  logic                                in_sel,
    input  logic [pdcd_pkg::SAMPLE_BITS-1:0]    in_sample,
    input  logic [pdcd_pkg::TIME_W-1:0]         in_time,
    input  logic                                cfg_valid,
    input  logic [pdcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                out_sel,
    output logic [pdcd_pkg::PCT_W-1:0]          out_percent,
    output logic                                out_contact,
    output logic                                out_zone,
    output logic [pdcd_pkg::PCT_W-1:0]          out_grip
);

    // configuration registers
    logic [pdcd_pkg::WEIGHT_W-1:0]   filter_alpha_reg;
    logic [pdcd_pkg::WEIGHT_W-1:0]   track_alpha_reg;
    logic [pdcd_pkg::FS_W-1:0]       full_scale_reg;
    logic [pdcd_pkg::DEADBAND_W-1:0] deadband_reg;
    logic [pdcd_pkg::PCT_W-1:0]      threshold_reg;
    logic [pdcd_pkg::TIMEOUT_W-1:0]  timeout_reg;

    // per-sensor state
    logic [pdcd_pkg::Q_W-1:0]         filtered_reg [pdcd_pkg::SENSOR_COUNT];
    logic [pdcd_pkg::SAMPLE_BITS-1:0] baseline_reg [pdcd_pkg::SENSOR_COUNT];
    logic [pdcd_pkg::PCT_W-1:0]       stored_pct_reg [pdcd_pkg::SENSOR_COUNT];
    logic                             contact_reg [pdcd_pkg::SENSOR_COUNT];
    logic [pdcd_pkg::TIME_W-1:0]      last_contact_reg [pdcd_pkg::SENSOR_COUNT];

    // item in progress
    logic                             func_reg;
    logic                             sel_reg;
    logic [pdcd_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic [pdcd_pkg::TIME_W-1:0]      time_reg;
    logic [pdcd_pkg::Q_W-1:0]         f_reg;
    logic [pdcd_pkg::SAMPLE_BITS-1:0] b_reg;
    logic [pdcd_pkg::PROD_W-1:0]      prod_reg;
    logic [pdcd_pkg::Q_W-1:0]         drop_reg;
    logic                             zone_reg;
    logic [pdcd_pkg::PCT_W-1:0]       pct_reg;
    logic [pdcd_pkg::NUM_W-1:0]       rem_reg;
    logic [pdcd_pkg::NUM_W-1:0]       den_reg;

    // result stage
    logic                             out_valid_reg;
    logic                             out_sel_reg;
    logic [pdcd_pkg::PCT_W-1:0]       out_pct_reg;
    logic                             out_contact_reg;
    logic                             out_zone_reg;
    logic [pdcd_pkg::PCT_W-1:0]       out_grip_reg;

    logic [pdcd_pkg::WEIGHT_W-1:0]    a_w;
    logic [pdcd_pkg::WEIGHT_W-1:0]    t_w;
    logic [pdcd_pkg::WEIGHT_W-1:0]    mul_a;
    logic [pdcd_pkg::Q_W-1:0]         mul_b;
    logic [pdcd_pkg::PROD_W-1:0]      mul_out;
    logic [pdcd_pkg::ACC_W-1:0]       acc;
    logic [pdcd_pkg::Q_W-1:0]         bq;
    logic [pdcd_pkg::Q_W-1:0]         drop_calc;
    logic [pdcd_pkg::NUM_W-1:0]       db_q;
    logic [pdcd_pkg::NUM_W-1:0]       delta;
    logic [pdcd_pkg::NUM_W-1:0]       d_q;
    logic [pdcd_pkg::NUM_W-1:0]       delta_scaled;
    logic [pdcd_pkg::NUM_W-1:0]       sat_limit;
    logic                             saturate;
    logic                             sel_valid;
    logic                             new_contact;
    logic                             timed_out;
    logic [pdcd_pkg::TIME_W-1:0]      elapsed;
    logic [pdcd_pkg::PCT_W-1:0]       grip;

    assign sel_valid = (32'(sel_reg) < pdcd_pkg::SENSOR_COUNT);

    // weights above one act as one
    assign a_w = filter_alpha_reg[pdcd_pkg::WEIGHT_W-1] ? pdcd_pkg::ONE_Q16 : filter_alpha_reg;
    assign t_w = track_alpha_reg[pdcd_pkg::WEIGHT_W-1] ? pdcd_pkg::ONE_Q16 : track_alpha_reg;

    // shared multiplier, operands chosen by the current step
    always_comb begin
        mul_a = pdcd_pkg::ONE_Q16 - t_w;
        mul_b = {b_reg, {pdcd_pkg::FRAC_BITS{1'b0}}};
        if (cmd.filt_mul) begin
            mul_a = a_w;
            mul_b = {sample_reg, {pdcd_pkg::FRAC_BITS{1'b0}}};
        end else if (cmd.filt_acc) begin
            mul_a = pdcd_pkg::ONE_Q16 - a_w;
            mul_b = f_reg;
        end else if (cmd.trk_mul) begin
            mul_a = t_w;
            mul_b = f_reg;
        end
    end

    assign mul_out = pdcd_pkg::PROD_W'(mul_a) * pdcd_pkg::PROD_W'(mul_b);
    assign acc     = pdcd_pkg::ACC_W'(prod_reg) + pdcd_pkg::ACC_W'(mul_out)
                   + (cmd.filt_acc ? pdcd_pkg::FILT_ROUND : pdcd_pkg::TRK_ROUND);

    // drop below baseline and deadband
    assign bq        = {b_reg, {pdcd_pkg::FRAC_BITS{1'b0}}};
    assign drop_calc = (bq > f_reg) ? (bq - f_reg) : '0;
    assign db_q      = pdcd_pkg::NUM_W'({deadband_reg, {pdcd_pkg::FRAC_BITS{1'b0}}});
    assign delta     = (pdcd_pkg::NUM_W'(drop_reg) > db_q)
                     ? (pdcd_pkg::NUM_W'(drop_reg) - db_q) : '0;
    assign d_q       = pdcd_pkg::NUM_W'({full_scale_reg, {pdcd_pkg::FRAC_BITS{1'b0}}});
    assign delta_scaled = pdcd_pkg::PCT_SCALE * delta;
    assign sat_limit    = pdcd_pkg::PCT_SAT_MUL * d_q;
    assign saturate     = (delta_scaled >= sat_limit);

    // contact and release decision
    assign new_contact = (pct_reg >= threshold_reg);
    assign elapsed     = time_reg - last_contact_reg[sel_reg];
    assign timed_out   = (elapsed > pdcd_pkg::TIME_W'(timeout_reg));

    always_comb begin
        grip = '0;
        for (int i = 0; i < pdcd_pkg::SENSOR_COUNT; i++) begin
            if (stored_pct_reg[i] > grip) begin
                grip = stored_pct_reg[i];
            end
        end
    end

    assign status.is_update  = (func_reg == pdcd_pkg::FUNC_UPDATE) && sel_valid;
    assign status.above_base = (f_reg > bq);
    assign status.zone       = zone_reg;
    assign status.div_needed = (full_scale_reg != '0) && !saturate;
    assign status.out_free   = !out_valid_reg || out_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_alpha_reg <= pdcd_pkg::FILTER_ALPHA_RST;
            track_alpha_reg  <= pdcd_pkg::TRACK_ALPHA_RST;
            full_scale_reg   <= pdcd_pkg::FULL_SCALE_RST;
            deadband_reg     <= pdcd_pkg::DEADBAND_RST;
            threshold_reg    <= pdcd_pkg::THRESHOLD_RST;
            timeout_reg      <= pdcd_pkg::TIMEOUT_RST;
        end else if (cfg_valid) begin
            unique case (pdcd_pkg::cfg_index_t'(cfg_index))
                pdcd_pkg::CFG_FILTER_ALPHA: filter_alpha_reg <= cfg_data;
                pdcd_pkg::CFG_TRACK_ALPHA:  track_alpha_reg  <= cfg_data;
                pdcd_pkg::CFG_FULL_SCALE:   full_scale_reg   <= cfg_data[pdcd_pkg::FS_W-1:0];
                pdcd_pkg::CFG_DEADBAND:     deadband_reg <= cfg_data[pdcd_pkg::DEADBAND_W-1:0];
                pdcd_pkg::CFG_THRESHOLD:    threshold_reg    <= cfg_data[pdcd_pkg::PCT_W-1:0];
                pdcd_pkg::CFG_TIMEOUT:      timeout_reg <= cfg_data[pdcd_pkg::TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // per-sensor state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pdcd_pkg::SENSOR_COUNT; i++) begin
                filtered_reg[i]     <= {pdcd_pkg::SAMPLE_MAX, {pdcd_pkg::FRAC_BITS{1'b0}}};
                baseline_reg[i]     <= pdcd_pkg::SAMPLE_MAX;
                stored_pct_reg[i]   <= '0;
                contact_reg[i]      <= 1'b0;
                last_contact_reg[i] <= '0;
            end
        end else if (cmd.commit && sel_valid) begin
            if (func_reg == pdcd_pkg::FUNC_INIT) begin
                filtered_reg[sel_reg]     <= {sample_reg, {pdcd_pkg::FRAC_BITS{1'b0}}};
                baseline_reg[sel_reg]     <= sample_reg;
                stored_pct_reg[sel_reg]   <= '0;
                contact_reg[sel_reg]      <= 1'b0;
                last_contact_reg[sel_reg] <= '0;
            end else begin
                filtered_reg[sel_reg] <= f_reg;
                baseline_reg[sel_reg] <= b_reg;
                contact_reg[sel_reg]  <= new_contact;
                if (new_contact) begin
                    stored_pct_reg[sel_reg]   <= pct_reg;
                    last_contact_reg[sel_reg] <= time_reg;
                end else if (zone_reg || timed_out) begin
                    stored_pct_reg[sel_reg] <= '0;
                end else begin
                    stored_pct_reg[sel_reg] <= pct_reg;
                end
            end
        end
    end

    // working registers of the item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg   <= in_func;
            sel_reg    <= in_sel;
            sample_reg <= in_sample;
            time_reg   <= in_time;
            f_reg      <= filtered_reg[in_sel];
            b_reg      <= baseline_reg[in_sel];
            zone_reg   <= 1'b0;
        end
        if (cmd.filt_mul || cmd.trk_mul) begin
            prod_reg <= mul_out;
        end
        if (cmd.filt_acc) begin
            f_reg <= acc[16 +: pdcd_pkg::Q_W];
        end
        if (cmd.trk_acc) begin
            b_reg <= acc[16 + pdcd_pkg::FRAC_BITS +: pdcd_pkg::SAMPLE_BITS];
        end
        if (cmd.zone_calc) begin
            drop_reg <= drop_calc;
            zone_reg <= (pdcd_pkg::NUM_W'(drop_calc) <= db_q);
        end
        if (cmd.pct_calc) begin
            rem_reg <= delta_scaled + d_q;
            den_reg <= d_q << pdcd_pkg::PCT_W;
            if (full_scale_reg == '0) begin
                pct_reg <= (delta != '0) ? pdcd_pkg::PCT_FULL : '0;
            end else if (saturate) begin
                pct_reg <= pdcd_pkg::PCT_FULL;
            end else begin
                pct_reg <= '0;
            end
        end
        if (cmd.div_step) begin
            den_reg <= den_reg >> 1;
            if (rem_reg >= den_reg) begin
                rem_reg <= rem_reg - den_reg;
                pct_reg <= {pct_reg[pdcd_pkg::PCT_W-2:0], 1'b1};
            end else begin
                pct_reg <= {pct_reg[pdcd_pkg::PCT_W-2:0], 1'b0};
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_sel_reg     <= sel_reg;
            out_pct_reg     <= sel_valid ? stored_pct_reg[sel_reg] : '0;
            out_contact_reg <= sel_valid ? contact_reg[sel_reg] : 1'b0;
            out_zone_reg    <= zone_reg;
            out_grip_reg    <= grip;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_sel     = out_sel_reg;
    assign out_percent = out_pct_reg;
    assign out_contact = out_contact_reg;
    assign out_zone    = out_zone_reg;
    assign out_grip    = out_grip_reg;

endmodule

>>> hdl/pressure_drop_contact_detector_core.sv
// an init item goes from capture straight to commit and report; an update item also walks
// the filter, the optional baseline tracking steps and, when it is needed, the percent divider
// one item at a time: the next item is taken only after the result is registered, and the
// shared 17x18 multiplier and the one-bit-per-cycle divider serve that single item
// reset: aresetn is synchronous and active low; registers return to their defaults and
// every sensor to baseline 1023, percent 0, no contact
module pressure_drop_contact_detector_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [47:0]                          s_tdata,   // sample[9:0], time_ms[41:10], zero pad
    input  logic [1:0]                           s_tuser,   // func[0], sensor_select[1]

    // result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,   // pressure_percent[6:0], contact[7],
                                                            // in_release_zone[8], grip_percent[15:9]
    output logic [0:0]                           m_tuser,   // sensor_out[0]

    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pdcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pdcd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pdcd_pkg::cmd_t                     cmd;
    pdcd_pkg::status_t                  status;
    logic                               in_ready;
    logic                               out_sel;
    logic [pdcd_pkg::PCT_W-1:0]         out_percent;
    logic                               out_contact;
    logic                               out_zone;
    logic [pdcd_pkg::PCT_W-1:0]         out_grip;

    // registers may be written at any time, the block never stalls the write
    assign cfg_ready = 1'b1;

    // sequencer: walks filter, tracking, deadband, percent, commit and report steps
    pdcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: configuration and sensor state, shared multiplier, divider and the result register
    pdcd_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_func     (s_tuser[0]),
        .in_sel      (s_tuser[1]),
        .in_sample   (s_tdata[pdcd_pkg::SAMPLE_BITS-1:0]),
        .in_time     (s_tdata[pdcd_pkg::SAMPLE_BITS +: pdcd_pkg::TIME_W]),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_sel     (out_sel),
        .out_percent (out_percent),
        .out_contact (out_contact),
        .out_zone    (out_zone),
        .out_grip    (out_grip)
    );

    // ready only while no item is in flight
    assign s_tready = in_ready;

    // pack the result item
    assign m_tdata = {out_grip, out_zone, out_contact, out_percent};
    assign m_tuser = out_sel;

    // a reported percent never exceeds 100
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= 7'd100))
        else $error("reported percent above 100");

    // without contact, a drop inside the deadband clears the stored percent
    a_release_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8] && !m_tdata[7]) |-> (m_tdata[6:0] == 7'd0))
        else $error("percent kept inside release zone");

    // the grip figure covers the reported sensor
    a_grip_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:9] >= m_tdata[6:0]))
        else $error("grip below sensor percent");

    // a new item is never taken while the sequencer is busy
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

endmodule

>>> bench/pressure_drop_contact_detector_core_tb.sv
module pressure_drop_contact_detector_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no handshake on any channel before the run is called hung
    localparam int STALL_LIMIT = 2000;
    // receiver hold-off used to fill the block and stall its input
    localparam int HOLD_CYCLES = 400;

    // one reading as the block reports it
    typedef struct packed {
        logic                       sensor;
        logic [pdcd_pkg::PCT_W-1:0] pct;
        logic                       contact;
        logic                       zone;
        logic [pdcd_pkg::PCT_W-1:0] grip;
    } reading_t;

    // clock, reset and block ports
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [47:0]                     s_tdata   = '0;   // sample[9:0], time_ms[41:10], zero pad
    logic [1:0]                      s_tuser   = '0;   // func[0], sensor_select[1]
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [15:0]                     m_tdata;          // pct[6:0], contact[7], zone[8], grip[15:9]
    logic [0:0]                      m_tuser;          // sensor_out[0]
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pdcd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pdcd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // register copies, kept in step with every write
    logic [pdcd_pkg::WEIGHT_W-1:0]   reg_filter_alpha = pdcd_pkg::FILTER_ALPHA_RST;
    logic [pdcd_pkg::WEIGHT_W-1:0]   reg_track_alpha  = pdcd_pkg::TRACK_ALPHA_RST;
    logic [pdcd_pkg::FS_W-1:0]       reg_full_scale   = pdcd_pkg::FULL_SCALE_RST;
    logic [pdcd_pkg::DEADBAND_W-1:0] reg_deadband     = pdcd_pkg::DEADBAND_RST;
    logic [pdcd_pkg::PCT_W-1:0]      reg_threshold    = pdcd_pkg::THRESHOLD_RST;
    logic [pdcd_pkg::TIMEOUT_W-1:0]  reg_timeout      = pdcd_pkg::TIMEOUT_RST;

    // per-sensor state of the detector as predicted
    logic [pdcd_pkg::Q_W-1:0]         filt_q   [pdcd_pkg::SENSOR_COUNT] =
        '{default: {pdcd_pkg::SAMPLE_MAX, {pdcd_pkg::FRAC_BITS{1'b0}}}};
    logic [pdcd_pkg::SAMPLE_BITS-1:0] base     [pdcd_pkg::SENSOR_COUNT] =
        '{default: pdcd_pkg::SAMPLE_MAX};
    logic [pdcd_pkg::PCT_W-1:0]       pct_mem  [pdcd_pkg::SENSOR_COUNT] = '{default: '0};
    logic                             touch    [pdcd_pkg::SENSOR_COUNT] = '{default: 1'b0};
    logic [pdcd_pkg::TIME_W-1:0]      touch_ms [pdcd_pkg::SENSOR_COUNT] = '{default: '0};

    // readings predicted but not yet seen at the output
    reading_t pending_readings[$];

    // stimulus shaping
    bit          gaps_on         = 1'b1;
    bit          sink_stalls_on  = 1'b1;
    int          sink_hold_left  = 0;
    logic [31:0] now_ms          = '0;
    int          rest_lvl   [pdcd_pkg::SENSOR_COUNT] = '{default: 600};
    int          press_pos  [pdcd_pkg::SENSOR_COUNT] = '{default: 0};
    int          press_len  [pdcd_pkg::SENSOR_COUNT] = '{default: 0};
    int          press_peak [pdcd_pkg::SENSOR_COUNT] = '{default: 0};

    // bookkeeping
    int fault_count     = 0;
    int items_sent      = 0;
    int readings_seen   = 0;
    int contacts_seen   = 0;
    int zone_seen       = 0;
    int cfg_writes      = 0;
    int quiet_cycles    = 0;

    pressure_drop_contact_detector_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // a weight above 1.0 behaves as exactly 1.0
    function automatic longint unsigned eff_weight(input logic [pdcd_pkg::WEIGHT_W-1:0] w);
        return (w > pdcd_pkg::ONE_Q16) ? 64'd65536 : 64'(w);
    endfunction

    // one baseline tracking step toward the filtered value, rounded half up
    function automatic logic [pdcd_pkg::SAMPLE_BITS-1:0] track_base(
            input logic [pdcd_pkg::SAMPLE_BITS-1:0] b, input logic [pdcd_pkg::Q_W-1:0] f);
        longint unsigned t, bq, acc;
        t   = eff_weight(reg_track_alpha);
        bq  = 64'(b) << pdcd_pkg::FRAC_BITS;
        acc = t * 64'(f) + (64'd65536 - t) * bq + (64'd1 << (15 + pdcd_pkg::FRAC_BITS));
        return pdcd_pkg::SAMPLE_BITS'(acc >> (16 + pdcd_pkg::FRAC_BITS));
    endfunction

    // advances the predicted sensor state by one item and returns its reading
    function automatic reading_t compute_reading(input pdcd_pkg::func_t fn, input logic sel,
                                                 input logic [pdcd_pkg::SAMPLE_BITS-1:0] smp,
                                                 input logic [pdcd_pkg::TIME_W-1:0] tms);
        reading_t r;
        longint unsigned a, fq, bq, drop, dbq, delta, dq, pct;
        logic [pdcd_pkg::Q_W-1:0] f;
        logic [pdcd_pkg::SAMPLE_BITS-1:0] b;
        logic zone;
        int i;
        zone = 1'b0;
        if (fn == pdcd_pkg::FUNC_INIT) begin
            base[sel]     = smp;
            filt_q[sel]   = pdcd_pkg::Q_W'(smp) << pdcd_pkg::FRAC_BITS;
            pct_mem[sel]  = '0;
            touch[sel]    = 1'b0;
            touch_ms[sel] = '0;
        end else begin
            // moving average with half-up rounding
            a  = eff_weight(reg_filter_alpha);
            fq = (a * (64'(smp) << pdcd_pkg::FRAC_BITS) + (64'd65536 - a) * 64'(filt_q[sel])
                  + 64'd32768) >> 16;
            f  = pdcd_pkg::Q_W'(fq);
            filt_q[sel] = f;
            b = base[sel];
            // baseline follows a rising filter first
            if (64'(f) > (64'(b) << pdcd_pkg::FRAC_BITS))
                b = track_base(b, f);
            bq   = 64'(b) << pdcd_pkg::FRAC_BITS;
            drop = (bq > 64'(f)) ? bq - 64'(f) : 64'd0;
            dbq  = 64'(reg_deadband) << pdcd_pkg::FRAC_BITS;
            zone = (drop <= dbq);
            // and keeps following while the drop sits in the deadband
            if (zone)
                b = track_base(b, f);
            base[sel] = b;
            delta = (drop > dbq) ? drop - dbq : 64'd0;
            if (reg_full_scale == '0) begin
                pct = (delta > 0) ? 64'd100 : 64'd0;
            end else begin
                dq  = 64'(reg_full_scale) << pdcd_pkg::FRAC_BITS;
                pct = (64'd200 * delta + dq) / (64'd2 * dq);
                if (pct > 100)
                    pct = 64'd100;
            end
            touch[sel]   = (pct >= 64'(reg_threshold));
            pct_mem[sel] = pdcd_pkg::PCT_W'(pct);
            if (touch[sel])
                touch_ms[sel] = tms;
            else if (zone || ((tms - touch_ms[sel]) > pdcd_pkg::TIME_W'(reg_timeout)))
                pct_mem[sel] = '0;
        end
        r.sensor  = sel;
        r.pct     = pct_mem[sel];
        r.contact = touch[sel];
        r.zone    = zone;
        r.grip    = '0;
        for (i = 0; i < pdcd_pkg::SENSOR_COUNT; i++)
            if (pct_mem[i] > r.grip)
                r.grip = pct_mem[i];
        return r;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // millisecond clock: small steps, some jumps past the timeout, now and then a wrap
    function automatic logic [pdcd_pkg::TIME_W-1:0] advance_ms();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r == 0)
            now_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
        else if (r < 6)
            now_ms = now_ms + $urandom_range(200, 70000);
        else
            now_ms = now_ms + $urandom_range(1, 15);
        return now_ms;
    endfunction

    // offers one item and records its prediction once it is taken
    task automatic send_item(input pdcd_pkg::func_t fn, input logic sel,
                             input logic [pdcd_pkg::SAMPLE_BITS-1:0] smp,
                             input logic [pdcd_pkg::TIME_W-1:0] tms);
        int unsigned gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {sel, fn};
        s_tdata  <= {6'b0, tms, smp};
        do @(posedge aclk); while (!s_tready);
        pending_readings.push_back(compute_reading(fn, sel, smp, tms));
        items_sent++;
    endtask

    // stops offering and waits for every outstanding reading
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input pdcd_pkg::cfg_index_t idx,
                                  input logic [pdcd_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pdcd_pkg::CFG_FILTER_ALPHA: reg_filter_alpha = val;
            pdcd_pkg::CFG_TRACK_ALPHA:  reg_track_alpha  = val;
            pdcd_pkg::CFG_FULL_SCALE:   reg_full_scale   = val[pdcd_pkg::FS_W-1:0];
            pdcd_pkg::CFG_DEADBAND:     reg_deadband     = val[pdcd_pkg::DEADBAND_W-1:0];
            pdcd_pkg::CFG_THRESHOLD:    reg_threshold    = val[pdcd_pkg::PCT_W-1:0];
            pdcd_pkg::CFG_TIMEOUT:      reg_timeout      = val[pdcd_pkg::TIMEOUT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_registers(input int unsigned fa, input int unsigned ta,
                                 input int unsigned fs, input int unsigned db,
                                 input int unsigned th, input int unsigned tmo);
        wait_drain();
        write_register(pdcd_pkg::CFG_FILTER_ALPHA, pdcd_pkg::CFG_DATA_W'(fa));
        write_register(pdcd_pkg::CFG_TRACK_ALPHA, pdcd_pkg::CFG_DATA_W'(ta));
        write_register(pdcd_pkg::CFG_FULL_SCALE, pdcd_pkg::CFG_DATA_W'(fs));
        write_register(pdcd_pkg::CFG_DEADBAND, pdcd_pkg::CFG_DATA_W'(db));
        write_register(pdcd_pkg::CFG_THRESHOLD, pdcd_pkg::CFG_DATA_W'(th));
        write_register(pdcd_pkg::CFG_TIMEOUT, pdcd_pkg::CFG_DATA_W'(tmo));
    endtask

    // field extremes, init and update, tracking up, contact, release, timeout and its wrap
    task automatic run_directed();
        int k;
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b0, 10'd1023, 32'd0);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'd0, 32'hFFFF_FFFF);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'd0, 32'd0);
        send_item(pdcd_pkg::FUNC_INIT, 1'b1, 10'd1023, 32'd1);
        send_item(pdcd_pkg::FUNC_INIT, 1'b0, 10'd0, 32'd2);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b0, 10'd1023, 32'd3);
        send_item(pdcd_pkg::FUNC_INIT, 1'b0, 10'd600, 32'd10);
        for (k = 0; k < 6; k++)
            send_item(pdcd_pkg::FUNC_UPDATE, 1'b0, 10'd585, 32'd11 + 32'(k));
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'd1000, 32'd17);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b0, 10'd596, 32'd20);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b0, 10'd596, 32'd400);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b0, 10'd600, 32'd401);
        // contact just before the millisecond counter wraps
        send_item(pdcd_pkg::FUNC_INIT, 1'b1, 10'd700, 32'hFFFF_FFF0);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'd600, 32'hFFFF_FFF8);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'd600, 32'hFFFF_FFFC);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'd600, 32'h0000_0004);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'd690, 32'h0000_0064);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'd690, 32'h0000_0200);
        // alternating bit patterns on sample and time
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b0, 10'h2AA, 32'h5555_5555);
        send_item(pdcd_pkg::FUNC_UPDATE, 1'b1, 10'h155, 32'hAAAA_AAAA);
    endtask

    // mostly press profiles per sensor with random content, some noise items
    task automatic run_random_phase(input int n);
        int k, d, smp, tri_pos;
        logic sel;
        for (k = 0; k < n; k++) begin
            if (k % 40 == 0) begin
                gaps_on        = ($urandom_range(0, 3) != 0);
                sink_stalls_on = ($urandom_range(0, 3) != 0);
            end
            sel = 1'($urandom_range(0, pdcd_pkg::SENSOR_COUNT - 1));
            if ($urandom_range(0, 99) < 8) begin
                send_item(pdcd_pkg::func_t'($urandom_range(0, 1)), sel,
                          pdcd_pkg::SAMPLE_BITS'($urandom_range(0, 1023)), $urandom());
            end else begin
                if (press_pos[sel] >= press_len[sel]) begin
                    press_pos[sel]  = 0;
                    press_len[sel]  = $urandom_range(4, 30);
                    press_peak[sel] = $urandom_range(0, 3 * (reg_full_scale + reg_deadband) / 2 + 4);
                    if ($urandom_range(0, 2) == 0) begin
                        rest_lvl[sel] = $urandom_range(20, 1023);
                        send_item(pdcd_pkg::FUNC_INIT, sel,
                                  pdcd_pkg::SAMPLE_BITS'(rest_lvl[sel]), advance_ms());
                    end
                end
                // triangular drop over the press, with a little noise
                tri_pos = (press_pos[sel] <= press_len[sel] / 2) ? press_pos[sel]
                                                                 : press_len[sel] - press_pos[sel];
                d   = press_peak[sel] * 2 * tri_pos / press_len[sel]
                      + int'($urandom_range(0, 2)) - 1;
                smp = rest_lvl[sel] - d;
                if (smp < 0)
                    smp = 0;
                else if (smp > 1023)
                    smp = 1023;
                press_pos[sel]++;
                send_item(pdcd_pkg::FUNC_UPDATE, sel, pdcd_pkg::SAMPLE_BITS'(smp), advance_ms());
            end
        end
    endtask

    // defaults, then the extremes of every register, then mid values, then the defaults again
    task automatic run_register_sweep();
        run_random_phase(85);
        set_registers(65536, 0, 1, 0, 0, 0);
        run_random_phase(85);
        set_registers(131071, 131071, 1023, 1023, 100, 65535);
        run_random_phase(85);
        set_registers(0, 65536, 0, 5, 127, 10);
        run_random_phase(85);
        set_registers($urandom_range(3000, 40000), $urandom_range(1000, 30000),
                      $urandom_range(8, 64), $urandom_range(0, 6),
                      $urandom_range(5, 60), $urandom_range(20, 300));
        run_random_phase(85);
        set_registers(pdcd_pkg::FILTER_ALPHA_RST, pdcd_pkg::TRACK_ALPHA_RST,
                      pdcd_pkg::FULL_SCALE_RST, pdcd_pkg::DEADBAND_RST,
                      pdcd_pkg::THRESHOLD_RST, pdcd_pkg::TIMEOUT_RST);
        run_random_phase(85);
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic run_backpressure();
        int k;
        gaps_on        = 1'b0;
        sink_hold_left = HOLD_CYCLES;
        for (k = 0; k < 12; k++)
            send_item(pdcd_pkg::FUNC_UPDATE, k[0],
                      pdcd_pkg::SAMPLE_BITS'($urandom_range(300, 700)), advance_ms());
    endtask

    // short bursts, each started after a full drain
    task automatic run_drain_pause();
        int k, j;
        gaps_on        = 1'b1;
        sink_stalls_on = 1'b1;
        for (k = 0; k < 3; k++) begin
            wait_drain();
            for (j = 0; j < 4; j++)
                send_item(pdcd_pkg::FUNC_UPDATE, 1'($urandom_range(0, 1)),
                          pdcd_pkg::SAMPLE_BITS'($urandom_range(0, 1023)), advance_ms());
        end
    endtask

    // receiver: long hold when asked, otherwise random stalls or always ready
    initial begin : sink_ctrl
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold_left > 0) begin
                m_tready <= 1'b0;
                sink_hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
                m_tready   <= 1'b0;
                stall_left = pick_gap();
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // every reading taken is compared with the oldest prediction
    always @(posedge aclk) begin : reading_check
        reading_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.sensor  = m_tuser[0];
            got.pct     = m_tdata[6:0];
            got.contact = m_tdata[7];
            got.zone    = m_tdata[8];
            got.grip    = m_tdata[15:9];
            if (pending_readings.size() == 0) begin
                if (fault_count < 10)
                    $display({"%t unexpected reading: sensor %0d pct %0d contact %b",
                              " zone %b grip %0d"},
                             $realtime, got.sensor, got.pct, got.contact, got.zone, got.grip);
                fault_count++;
            end else begin
                want = pending_readings.pop_front();
                readings_seen++;
                if (want.contact)
                    contacts_seen++;
                if (want.zone)
                    zone_seen++;
                if (got.sensor !== want.sensor || got.pct !== want.pct ||
                    got.contact !== want.contact || got.zone !== want.zone ||
                    got.grip !== want.grip) begin
                    if (fault_count < 10)
                        $display({"%t reading mismatch: sensor %0d/%0d pct %0d/%0d contact %b/%b",
                                  " zone %b/%b grip %0d/%0d (expected/actual)"}, $realtime,
                                 want.sensor, got.sensor, want.pct, got.pct, want.contact,
                                 got.contact, want.zone, got.zone, want.grip, got.grip);
                    fault_count++;
                end
            end
        end
    end

    // watchdog: ends the run when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d readings outstanding",
                     quiet_cycles, pending_readings.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_register_sweep();
        run_backpressure();
        run_drain_pause();
        wait_drain();
        repeat (30) @(posedge aclk);
        if (pending_readings.size() != 0)
            fault_count++;
        $display("run covered %0d items, %0d readings checked, %0d register writes",
                 items_sent, readings_seen, cfg_writes);
        $display("%0d readings with contact, %0d in the release zone, six settings, stalls",
                 contacts_seen, zone_seen);
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
